@@ src/oidber_pkg.sv @@
// Package for the object identifier BER content encoder.
// Holds the transfer payload types, status codes and controller types.
// Used by every module in src; depends on nothing.
package oidber_pkg;

	// Default arc width in bits; the top level takes it as a parameter.
	localparam int ARC_WIDTH_DEF = 64;

	// Fixed payload widths.
	localparam int IN_ARC_W  = 64;
	localparam int BYTE_W    = 8;
	localparam int STATUS_W  = 3;

	// Encoding constants.
	localparam int GROUP_BITS    = 7;
	localparam int FIRST_ARC_MAX = 2;
	localparam int SECOND_MAX    = 39;
	localparam int ARC_MULT      = 40;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_FIRST    = 3'd1,
		STAT_SECOND   = 3'd2,
		STAT_SHORT    = 3'd3,
		STAT_OVERFLOW = 3'd4
	} status_t;

	// Position within the identifier.
	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_LATER  = 2'd2,
		POS_SPARE  = 2'd3
	} arc_pos_t;

	// Input item: one arc.
	typedef struct packed {
		logic [IN_ARC_W-1:0] arc_value;
		logic                final_arc;
	} in_item_t;

	// Output item: one content byte.
	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                last_of_arc;
		logic                end_of_identifier;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_EMIT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic eval;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic has_result;
		logic last_group;
	} dp_stat_t;

endpackage

@@ src/oidber_ctrl.sv @@
// Controller state machine for the object identifier BER encoder.
// Sequences load, evaluate and byte emission, and owns the output valid flag.
// Depends on oidber_pkg.
module oidber_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output oidber_pkg::dp_cmd_t cmd,
	input  oidber_pkg::dp_stat_t stat
);
	import oidber_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        slot_free;

	// The output register can take a byte when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = stat.has_result ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					if (stat.last_group) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Output valid flag: set by a new byte, cleared when the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/oidber_dpath.sv @@
// Datapath for the object identifier BER encoder.
// Holds identifier state, forms the combined first value, and splits values
// into base-128 groups. Depends on oidber_pkg.
module oidber_dpath #(
	parameter int ARC_WIDTH = oidber_pkg::ARC_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  oidber_pkg::in_item_t in_data,
	input  oidber_pkg::dp_cmd_t  cmd,
	output oidber_pkg::dp_stat_t stat,
	output oidber_pkg::out_item_t out_data
);
	import oidber_pkg::*;

	localparam int NGROUPS = (ARC_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
	localparam int PADW    = NGROUPS * GROUP_BITS;
	localparam int KW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

	// Captured input.
	logic [ARC_WIDTH-1:0] arc_s1;
	logic                 fin_s1;

	// Identifier state.
	arc_pos_t             pos_q;
	logic [1:0]           held_q;
	logic                 err_seen_q;

	// Value being emitted.
	logic [ARC_WIDTH-1:0] value_q;
	logic [KW-1:0]        k_q;
	status_t              code_q;
	logic                 fin_q;
	out_item_t            out_q;

	// Evaluation results.
	logic [6:0]           base;
	logic [ARC_WIDTH:0]   sum;
	logic                 has_result;
	logic                 is_err;
	status_t              err_code;
	logic [ARC_WIDTH-1:0] emit_val;
	logic                 clear_st;
	logic                 set_err;
	arc_pos_t             pos_nxt;
	logic [PADW-1:0]      eval_pad;
	logic [KW-1:0]        k_start;
	logic [PADW-1:0]      out_pad;
	logic [GROUP_BITS-1:0] grp;

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			arc_s1 <= in_data.arc_value[ARC_WIDTH-1:0];
			fin_s1 <= in_data.final_arc;
		end
	end

	// Combined first value; the carry out of the sum flags overflow.
	assign base = 7'(held_q) * 7'(ARC_MULT);
	assign sum  = {1'b0, arc_s1} + (ARC_WIDTH+1)'(base);

	// Decide what the captured arc yields and how the state moves.
	always_comb begin
		has_result = 1'b0;
		is_err     = 1'b0;
		err_code   = STAT_OK;
		emit_val   = arc_s1;
		clear_st   = 1'b0;
		set_err    = 1'b0;
		pos_nxt    = pos_q;
		if (err_seen_q) begin
			clear_st = fin_s1;
		end else begin
			case (pos_q)
				POS_FIRST: begin
					if (fin_s1) begin
						is_err   = 1'b1;
						err_code = STAT_SHORT;
					end else if (arc_s1 > ARC_WIDTH'(FIRST_ARC_MAX)) begin
						is_err   = 1'b1;
						err_code = STAT_FIRST;
					end else begin
						pos_nxt = POS_SECOND;
					end
				end
				POS_SECOND: begin
					if (held_q < 2'd2 && arc_s1 > ARC_WIDTH'(SECOND_MAX)) begin
						is_err   = 1'b1;
						err_code = STAT_SECOND;
					end else if (sum[ARC_WIDTH]) begin
						is_err   = 1'b1;
						err_code = STAT_OVERFLOW;
					end else begin
						has_result = 1'b1;
						emit_val   = sum[ARC_WIDTH-1:0];
						pos_nxt    = POS_LATER;
					end
				end
				default: begin
					has_result = 1'b1;
					pos_nxt    = POS_LATER;
				end
			endcase
			if (is_err) begin
				has_result = 1'b1;
				emit_val   = '0;
				set_err    = !fin_s1;
			end
			clear_st = fin_s1 && has_result;
		end
	end

	// Index of the most significant nonzero group.
	assign eval_pad = PADW'(emit_val);
	always_comb begin
		k_start = '0;
		for (int g = 1; g < NGROUPS; g++) begin
			if (eval_pad[g*GROUP_BITS +: GROUP_BITS] != '0) begin
				k_start = KW'(g);
			end
		end
	end

	// Identifier state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_FIRST;
			held_q     <= '0;
			err_seen_q <= 1'b0;
		end else if (cmd.eval) begin
			if (clear_st) begin
				pos_q      <= POS_FIRST;
				held_q     <= '0;
				err_seen_q <= 1'b0;
			end else begin
				pos_q <= pos_nxt;
				if (set_err) begin
					err_seen_q <= 1'b1;
				end
				if (pos_q == POS_FIRST && pos_nxt == POS_SECOND) begin
					held_q <= arc_s1[1:0];
				end
			end
		end
	end

	// Emission registers: value, group counter, status and output byte.
	assign out_pad = PADW'(value_q);
	always_comb begin
		grp = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			if (k_q == KW'(g)) begin
				grp = out_pad[g*GROUP_BITS +: GROUP_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			value_q <= emit_val;
			k_q     <= is_err ? '0 : k_start;
			code_q  <= err_code;
			fin_q   <= fin_s1;
		end else if (cmd.emit) begin
			if (k_q != '0) begin
				k_q <= k_q - KW'(1);
			end
		end
		if (cmd.emit) begin
			out_q.out_byte          <= {(k_q != '0), grp};
			out_q.last_of_arc       <= (k_q == '0);
			out_q.end_of_identifier <= (k_q == '0) && fin_q;
			out_q.status            <= code_q;
		end
	end

	assign stat.has_result = has_result;
	assign stat.last_group = (k_q == '0);
	assign out_data        = out_q;

endmodule

@@ src/object_identifier_ber_encoder_top.sv @@
// Object identifier BER content encoder, top level.
// Instantiates the controller and the datapath; depends on oidber_pkg.
//
// Usage:
// Arcs arrive on the input channel (in_valid, in_ready, in_data), one per
// transfer, with final_arc set on the last arc of an identifier. Content
// bytes leave on the output channel (out_valid, out_ready, out_data), one
// per transfer, most significant base-128 group first.
// Timing: an arc is taken and then checked in the next cycle. An arc that
// yields N bytes (up to ten for a 64-bit arc) then occupies the block while
// it emits them, one byte per cycle while the output register is free. A
// first arc, an arc dropped after an error, and the arc ending a dropped
// identifier yield nothing; an error yields one byte. The first byte passes
// the input capture register, the evaluate state and the output register.
// The single output register lets the next arc be taken while the last
// byte still waits. When the receiver stalls, the block holds its byte and
// stops at the next byte until out_ready returns.
// Reset clears the identifier state and the output valid flag; the block
// leaves reset idle and ready to take an arc.
module object_identifier_ber_encoder_top #(
	parameter int ARC_WIDTH = oidber_pkg::ARC_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  oidber_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output oidber_pkg::out_item_t out_data
);
	import oidber_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	oidber_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Checking and encoding datapath.
	oidber_dpath #(
		.ARC_WIDTH (ARC_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

@@ src/oidber_checker.sv @@
// Port-level checker for the object identifier BER encoder, and its binding.
// Watches only the top level's ports; depends on oidber_pkg.
module oidber_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input oidber_pkg::in_item_t  in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input oidber_pkg::out_item_t out_data
);
	import oidber_pkg::*;

	// A waiting arc stays offered and unchanged until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> (in_valid && $stable(in_data)))
		else $error("input arc changed or dropped while waiting");

	// A stalled byte stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output byte changed or dropped while stalled");

	// An error result is a single zero byte that ends its arc.
	a_err_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != STAT_OK) |->
		(out_data.out_byte == '0 && out_data.last_of_arc))
		else $error("error result is not a lone zero byte");

	// Bytes before the last of an arc carry the continuation bit.
	a_cont_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.out_byte[7] == !out_data.last_of_arc))
		else $error("continuation bit does not match last_of_arc");

	// End of identifier only on the last byte of an arc.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.end_of_identifier) |-> out_data.last_of_arc)
		else $error("end_of_identifier set on a non-final byte");

endmodule

bind object_identifier_ber_encoder_top oidber_checker u_oidber_checker (.*);
